[rtl/ssm_pkg.sv]
// Shared types, constants and lookup functions of the scrolling seven-segment marquee.
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int DIGITS = 4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MESSAGE_LENGTH = 2'd0;
  localparam logic [1:0] CFG_TICK_DIVIDE    = 2'd1;
  localparam logic [1:0] CFG_SCROLL_STEP    = 2'd2;

  localparam logic [5:0] MESSAGE_LENGTH_RESET = 6'd20;
  localparam logic [7:0] TICK_DIVIDE_RESET    = 8'd10;
  localparam logic [3:0] SCROLL_STEP_RESET    = 4'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] DEMO_SPAN  = 8'd16;
  localparam logic [3:0] BLANK_CODE = 4'd10;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_IGNORE = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [4:0]  char_index;
    logic [7:0]  char_value;
    logic        tick;
    logic        left_press;
    logic        right_press;
    logic        toggle_press;
  } cmd_t;

  // Character held at a message position after reset: digits one to eight
  // separated by spaces, and spaces beyond them.
  function automatic logic [7:0] reset_char(input logic [7:0] idx);
    logic [7:0] ch;
    ch = CHAR_SPACE;
    if ((idx < DEMO_SPAN) && !idx[0]) begin
      ch = CHAR_ONE + {4'd0, idx[4:1]};
    end
    return ch;
  endfunction

  function automatic logic [6:0] seg_lookup(input logic [3:0] code);
    logic [6:0] seg;
    unique case (code)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

[rtl/ssm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ssm_front.sv]
// Front end: accepts input beats, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module ssm_front import ssm_pkg::*; #(
  parameter int MAX_MESSAGE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [4:0] char_index_i,
  input  logic [7:0] char_value_i,
  input  logic       tick_i,
  input  logic       left_press_i,
  input  logic       right_press_i,
  input  logic       toggle_press_i,
  output logic       head_valid_o,
  output cmd_t       head_o,
  input  logic       pop_i
);

  cmd_t       cmd;
  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  always_comb begin
    cmd.char_index   = char_index_i;
    cmd.char_value   = char_value_i;
    cmd.tick         = tick_i;
    cmd.left_press   = left_press_i;
    cmd.right_press  = right_press_i;
    cmd.toggle_press = toggle_press_i;
    if (!func_i) begin
      cmd.kind = CMD_POLL;
    end else if (int'(char_index_i) < MAX_MESSAGE) begin
      cmd.kind = CMD_WRITE;
    end else begin
      cmd.kind = CMD_IGNORE;
    end
  end

  assign in_stall_o   = (count_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != 2'd0))
    else $error("queue popped while empty");

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count out of range");

endmodule

[rtl/ssm_back.sv]
// Back end: configuration, scroll state, message store and the output register.
`timescale 1ns / 1ps

module ssm_back import ssm_pkg::*; #(
  parameter int MAX_MESSAGE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       head_valid_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] digit_position_o,
  output logic [6:0] segments_o,
  output logic [5:0] window_offset_o,
  output logic       running_o
);

  localparam int AddrW = $clog2(MAX_MESSAGE);

  logic [5:0] msg_len_q;
  logic [7:0] tick_div_q;
  logic [3:0] step_q;

  logic [7:0] tick_count_q, tick_count_d;
  logic       pending_q, pending_d;
  logic [5:0] offset_q, offset_d;
  logic       run_q, run_d;
  logic       right_q, right_d;
  logic [1:0] phase_q;

  logic [MAX_MESSAGE-1:0] written_q;

  logic             out_valid_q;
  logic [1:0]       pos_q;
  logic [5:0]       out_offset_q;
  logic             out_run_q;
  logic             use_mem_q;
  logic [AddrW-1:0] ridx_q;

  logic             slot_free, poll_fire, write_fire;
  logic [7:0]       tick_next;
  logic             pending_mid;
  logic [5:0]       len;
  logic [6:0]       len7;
  logic signed [7:0] off;
  logic [1:0]       pos;
  logic [6:0]       wrapped;
  logic [AddrW-1:0] ridx;
  logic [AddrW-1:0] waddr;
  logic [7:0]       rdata;
  logic [7:0]       shown_char;
  logic [7:0]       digit_raw;
  logic [3:0]       seg_code;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign poll_fire  = head_valid_i && (head_i.kind == CMD_POLL) && slot_free;
  assign write_fire = head_valid_i && (head_i.kind == CMD_WRITE);
  assign pop_o      = head_valid_i && ((head_i.kind != CMD_POLL) || slot_free);
  assign waddr      = AddrW'(head_i.char_index);

  // Effective message length: zero counts as one, and it never exceeds the store.
  always_comb begin
    len = msg_len_q;
    if (len == 6'd0) begin
      len = 6'd1;
    end
    if (int'(len) > MAX_MESSAGE) begin
      len = 6'(MAX_MESSAGE);
    end
    len7 = {1'b0, len};
  end

  always_comb begin
    tick_next    = tick_count_q + 8'd1;
    tick_count_d = tick_count_q;
    pending_mid  = pending_q;
    if (head_i.tick) begin
      if (tick_next == tick_div_q) begin
        pending_mid  = 1'b1;
        tick_count_d = 8'd0;
      end else begin
        tick_count_d = tick_next;
      end
    end

    right_d = right_q;
    if (head_i.left_press) begin
      right_d = 1'b0;
    end
    if (head_i.right_press) begin
      right_d = 1'b1;
    end
    run_d = run_q ^ head_i.toggle_press;

    off       = $signed({2'b00, offset_q});
    pending_d = pending_mid;
    if (pending_mid && run_d) begin
      if (right_d) begin
        off = off - $signed({4'd0, step_q});
      end else begin
        off = off + $signed({4'd0, step_q});
      end
      pending_d = 1'b0;
    end
    if (off > $signed({2'b00, len})) begin
      off = 8'sd0;
    end else if (off < 8'sd0) begin
      off = $signed({2'b00, len});
    end
    offset_d = off[5:0];

    pos = 2'(DIGITS - 1) - phase_q;

    // The sum stays below the length plus four, so three conditional
    // subtractions reduce it for every length above one.
    wrapped = 7'(offset_d) + 7'(pos);
    for (int i = 0; i < 3; i++) begin
      if (wrapped >= len7) begin
        wrapped = wrapped - len7;
      end
    end
    if (len == 6'd1) begin
      wrapped = 7'd0;
    end
    ridx = AddrW'(wrapped);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q  <= MESSAGE_LENGTH_RESET;
      tick_div_q <= TICK_DIVIDE_RESET;
      step_q     <= SCROLL_STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MESSAGE_LENGTH: msg_len_q  <= cfg_wdata_i[5:0];
        CFG_TICK_DIVIDE:    tick_div_q <= cfg_wdata_i;
        CFG_SCROLL_STEP:    step_q     <= cfg_wdata_i[3:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= 8'd0;
      pending_q    <= 1'b0;
      offset_q     <= 6'd0;
      run_q        <= 1'b1;
      right_q      <= 1'b0;
      phase_q      <= 2'd0;
      written_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (write_fire) begin
        written_q[waddr] <= 1'b1;
      end
      if (poll_fire) begin
        tick_count_q <= tick_count_d;
        pending_q    <= pending_d;
        offset_q     <= offset_d;
        run_q        <= run_d;
        right_q      <= right_d;
        phase_q      <= phase_q + 2'd1;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_fire) begin
      pos_q        <= pos;
      out_offset_q <= offset_d;
      out_run_q    <= run_d;
      use_mem_q    <= written_q[ridx];
      ridx_q       <= ridx;
    end
  end

  ssm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MESSAGE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (write_fire),
    .waddr_i (waddr),
    .wdata_i (head_i.char_value),
    .re_i    (poll_fire),
    .raddr_i (ridx),
    .rdata_o (rdata)
  );

  // Positions never written since reset still show the demo text.
  always_comb begin
    shown_char = use_mem_q ? rdata : reset_char(8'(ridx_q));
    digit_raw  = shown_char - CHAR_ZERO;
    seg_code   = (digit_raw > 8'(BLANK_CODE)) ? BLANK_CODE : digit_raw[3:0];
  end

  assign out_valid_o      = out_valid_q;
  assign digit_position_o = pos_q;
  assign segments_o       = seg_lookup(seg_code);
  assign window_offset_o  = out_offset_q;
  assign running_o        = out_run_q;

  a_offset_in_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(offset_q) <= MAX_MESSAGE)
    else $error("window offset beyond the message store");

  a_digit_rotation : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(poll_fire) |-> (out_valid_q && (pos_q == 2'(DIGITS - 1) - $past(phase_q))))
    else $error("digit rotation out of step");

  a_request_consumed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(poll_fire) && run_q) |-> !pending_q)
    else $error("scroll request left pending while running");

endmodule

[rtl/scrolling_seven_segment_marquee_unit.sv]
// Top level of the scrolling seven-segment marquee.
`timescale 1ns / 1ps

// The unit takes one beat per cycle unless the input stalls: a message character write
// or a poll. A poll counts the time-base tick, takes the buttons, scrolls the window on
// a pending request while running, and returns the segment pattern of one digit,
// rightmost digit first. A write returns nothing. Beats pass through a two-entry queue
// into the back end, which handles one beat per cycle unless the output stalls, so the
// sustained rate is one beat per cycle. A poll's result is registered in the queue,
// then in the output register, at the same edge as the registered read of the message
// store. While a result is stalled, the queue holds two more beats before the input
// stalls. Message positions never written since reset show the demo text.
module scrolling_seven_segment_marquee_unit import ssm_pkg::*; #(
  parameter int MAX_MESSAGE = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       func_i,
  input  logic [4:0] char_index_i,
  input  logic [7:0] char_value_i,
  input  logic       tick_i,
  input  logic       left_press_i,
  input  logic       right_press_i,
  input  logic       toggle_press_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] digit_position_o,
  output logic [6:0] segments_o,
  output logic [5:0] window_offset_o,
  output logic       running_o
);

  logic head_valid;
  cmd_t head;
  logic pop;

  ssm_front #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .char_index_i   (char_index_i),
    .char_value_i   (char_value_i),
    .tick_i         (tick_i),
    .left_press_i   (left_press_i),
    .right_press_i  (right_press_i),
    .toggle_press_i (toggle_press_i),
    .head_valid_o   (head_valid),
    .head_o         (head),
    .pop_i          (pop)
  );

  ssm_back #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .head_valid_i     (head_valid),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .window_offset_o  (window_offset_o),
    .running_o        (running_o)
  );

endmodule
